FILE: rtl/psrt_pkg.sv
// Shared types, constants and helper functions for the page slot rotation table.
// No dependencies; every other file except the checker refers to it by scoped names.
package psrt_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int IDX_W      = $clog2(SLOT_COUNT);
   localparam int PROD_W     = 26;

   localparam logic [15:0] DEFAULT_DWELL = 16'd600;
   localparam logic [15:0] ADDED_DWELL   = 16'd300;
   localparam logic [15:0] MIN_DWELL     = 16'd60;
   localparam logic [9:0]  MS_PER_S      = 10'd1000;
   localparam logic [2:0]  KIND_COUNT    = 3'd6;
   localparam logic [4:0]  MAX_HOUR      = 5'd23;
   localparam logic [4:0]  RESET_QFROM   = 5'd23;
   localparam logic [4:0]  RESET_QTO     = 5'd7;

   // action codes
   localparam logic [3:0] ACT_TICK       = 4'd0;
   localparam logic [3:0] ACT_DRAWN      = 4'd1;
   localparam logic [3:0] ACT_GOTO       = 4'd2;
   localparam logic [3:0] ACT_NEXT       = 4'd3;
   localparam logic [3:0] ACT_SET_ACTIVE = 4'd4;
   localparam logic [3:0] ACT_SET_DWELL  = 4'd5;
   localparam logic [3:0] ACT_PIN        = 4'd6;
   localparam logic [3:0] ACT_ADD        = 4'd7;
   localparam logic [3:0] ACT_MOVE       = 4'd8;
   localparam logic [3:0] ACT_REMOVE     = 4'd9;
   localparam logic [3:0] ACT_READ       = 4'd10;

   // register indexes
   localparam logic [1:0] CSR_ENABLE = 2'd0;
   localparam logic [1:0] CSR_QFROM  = 2'd1;
   localparam logic [1:0] CSR_QTO    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TICK_MUL,
      ST_TICK_CMP,
      ST_MOVE_RD,
      ST_MOVE_WR_S,
      ST_MOVE_WR_U,
      ST_DWELL_WR,
      ST_READ,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_CAPTURE,
      STEP_EXEC,
      STEP_TICK_MUL,
      STEP_TICK_CMP,
      STEP_MOVE_RD,
      STEP_MOVE_WR_S,
      STEP_MOVE_WR_U,
      STEP_DWELL_WR,
      STEP_READ,
      STEP_LOAD_RSP
   } step_type;

   typedef struct packed {
      step_type step;
   } cmd_type;

   typedef struct packed {
      logic [3:0] action;
      logic       go;
   } status_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] dwell;
   } entry_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
   } pick_type;

   function automatic entry_type reset_entry(input logic [IDX_W-1:0] idx);
      entry_type e;
      e = '0;
      if (idx == IDX_W'(0)) begin
         e.kind  = 3'd0;
         e.dwell = DEFAULT_DWELL;
      end else if (idx == IDX_W'(1)) begin
         e.kind  = 3'd1;
         e.dwell = ADDED_DWELL;
      end else if (idx == IDX_W'(2)) begin
         e.kind  = 3'd2;
         e.dwell = ADDED_DWELL;
      end
      return e;
   endfunction

   // lowest set bit
   function automatic pick_type first_set(input logic [SLOT_COUNT-1:0] v);
      pick_type p;
      p = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (v[i]) begin
            p.found = 1'b1;
            p.idx   = IDX_W'(i);
         end
      end
      return p;
   endfunction

   // highest set bit
   function automatic pick_type last_set(input logic [SLOT_COUNT-1:0] v);
      pick_type p;
      p = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (v[i]) begin
            p.found = 1'b1;
            p.idx   = IDX_W'(i);
         end
      end
      return p;
   endfunction

   // first set bit after cur, wrapping; cur itself counts last when incl is set
   function automatic pick_type next_after(input logic [SLOT_COUNT-1:0] v,
                                           input logic [IDX_W-1:0]      cur,
                                           input logic                  incl);
      logic [2*SLOT_COUNT-1:0] dbl;
      logic [SLOT_COUNT-1:0]   rot;
      pick_type                p;
      dbl = {v, v};
      rot = dbl[({1'b0, cur} + (IDX_W+1)'(1)) +: SLOT_COUNT];
      if (!incl) rot[SLOT_COUNT-1] = 1'b0;
      p = first_set(rot);
      p.idx = cur + IDX_W'(1) + p.idx;
      return p;
   endfunction

   function automatic logic in_quiet(input logic [4:0] qfrom,
                                     input logic [4:0] qto,
                                     input logic [4:0] hour);
      logic q;
      if (qfrom == qto)     q = 1'b0;
      else if (qfrom < qto) q = (hour >= qfrom) && (hour < qto);
      else                  q = (hour >= qfrom) || (hour < qto);
      return q;
   endfunction

endpackage

FILE: rtl/psrt_ctrl.sv
// Sequencer for the page slot rotation table: state machine and response valid.
// Depends on psrt_pkg; drives the datapath through cmd_type, reads status_type.
module psrt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  psrt_pkg::status_type   status,
   output psrt_pkg::cmd_type      cmd
);

   psrt_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != psrt_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psrt_pkg::ST_IDLE: begin
            if (req_valid) state_in = psrt_pkg::ST_EXEC;
         end
         psrt_pkg::ST_EXEC: begin
            unique case (status.action)
               psrt_pkg::ACT_TICK:
                  state_in = status.go ? psrt_pkg::ST_TICK_MUL : psrt_pkg::ST_DONE;
               psrt_pkg::ACT_SET_DWELL:
                  state_in = status.go ? psrt_pkg::ST_DWELL_WR : psrt_pkg::ST_DONE;
               psrt_pkg::ACT_MOVE:
                  state_in = status.go ? psrt_pkg::ST_MOVE_RD : psrt_pkg::ST_DONE;
               psrt_pkg::ACT_READ:
                  state_in = psrt_pkg::ST_READ;
               default:
                  state_in = psrt_pkg::ST_DONE;
            endcase
         end
         psrt_pkg::ST_TICK_MUL:  state_in = psrt_pkg::ST_TICK_CMP;
         psrt_pkg::ST_TICK_CMP:  state_in = psrt_pkg::ST_DONE;
         psrt_pkg::ST_MOVE_RD:   state_in = psrt_pkg::ST_MOVE_WR_S;
         psrt_pkg::ST_MOVE_WR_S: state_in = psrt_pkg::ST_MOVE_WR_U;
         psrt_pkg::ST_MOVE_WR_U: state_in = psrt_pkg::ST_DONE;
         psrt_pkg::ST_DWELL_WR:  state_in = psrt_pkg::ST_DONE;
         psrt_pkg::ST_READ:      state_in = psrt_pkg::ST_DONE;
         psrt_pkg::ST_DONE: begin
            if (out_free) state_in = psrt_pkg::ST_IDLE;
         end
         default: state_in = psrt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.step     = psrt_pkg::STEP_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         psrt_pkg::ST_IDLE: begin
            if (req_valid) cmd.step = psrt_pkg::STEP_CAPTURE;
         end
         psrt_pkg::ST_EXEC:      cmd.step = psrt_pkg::STEP_EXEC;
         psrt_pkg::ST_TICK_MUL:  cmd.step = psrt_pkg::STEP_TICK_MUL;
         psrt_pkg::ST_TICK_CMP:  cmd.step = psrt_pkg::STEP_TICK_CMP;
         psrt_pkg::ST_MOVE_RD:   cmd.step = psrt_pkg::STEP_MOVE_RD;
         psrt_pkg::ST_MOVE_WR_S: cmd.step = psrt_pkg::STEP_MOVE_WR_S;
         psrt_pkg::ST_MOVE_WR_U: cmd.step = psrt_pkg::STEP_MOVE_WR_U;
         psrt_pkg::ST_DWELL_WR:  cmd.step = psrt_pkg::STEP_DWELL_WR;
         psrt_pkg::ST_READ:      cmd.step = psrt_pkg::STEP_READ;
         psrt_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.step     = psrt_pkg::STEP_LOAD_RSP;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd.step = psrt_pkg::STEP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psrt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/psrt_dp.sv
// Datapath of the page slot rotation table: slot flags, kind/dwell memory,
// current slot, draw time, configuration and response registers. Depends on psrt_pkg.
module psrt_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  psrt_pkg::cmd_type      cmd,
   output psrt_pkg::status_type   status,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [4:0]             csr_wdata,
   input  logic [3:0]             req_action,
   input  logic [3:0]             req_slot,
   input  logic                   req_flag,
   input  logic [15:0]            req_dwell_seconds,
   input  logic [2:0]             req_page_kind,
   input  logic [31:0]            req_now_ms,
   input  logic [4:0]             req_hour_of_day,
   output logic                   rsp_ok,
   output logic [3:0]             rsp_result_slot,
   output logic [3:0]             rsp_current_slot,
   output logic                   rsp_entry_used,
   output logic                   rsp_entry_active,
   output logic [2:0]             rsp_entry_kind,
   output logic [15:0]            rsp_entry_dwell
);

   localparam int N = psrt_pkg::SLOT_COUNT;
   localparam int W = psrt_pkg::IDX_W;

   // configuration
   logic       en_ff;
   logic [4:0] qfrom_ff, qto_ff;

   // captured request
   logic [3:0]  act_ff;
   logic [W-1:0] slot_ff;
   logic        flag_ff;
   logic [15:0] dwell_ff;
   logic [2:0]  kind_ff;
   logic [31:0] now_ff;
   logic [4:0]  hour_ff;

   // table state
   logic [N-1:0] used_ff, used_in;
   logic [N-1:0] active_ff, active_in;
   logic [N-1:0] kd_valid_ff;
   logic [W-1:0] cur_ff, cur_in;
   logic [31:0]  last_ff, last_in;
   psrt_pkg::entry_type mem [N];

   // memory ports
   logic                mem_we;
   logic [W-1:0]        mem_wa;
   psrt_pkg::entry_type mem_wd;
   logic                rd_re;
   logic [W-1:0]        rd_ra;
   logic [W-1:0]        rd_addr_ff;
   logic                rd_valid_ff;
   psrt_pkg::entry_type mem_rd_ff;
   psrt_pkg::entry_type rd_data;

   // work registers
   logic [W-1:0]              u_ff, u_in;
   psrt_pkg::entry_type       hold_ff, hold_in;
   logic [psrt_pkg::PROD_W-1:0] prod_ff, prod_in;
   psrt_pkg::pick_type        nxt_ff, nxt_in;

   // pending result
   logic        ok_ff, ok_in;
   logic [W-1:0] res_ff, res_in;
   logic        eu_ff, eu_in, ea_ff, ea_in;
   logic [2:0]  ek_ff, ek_in;
   logic [15:0] ed_ff, ed_in;

   // decode helpers
   logic               s_used;
   logic [N-1:0]       s_hot;
   psrt_pkg::pick_type fix_pick, next_pick, free_pick, up_pick, down_pick, mv_pick, rm_pick;
   logic [W-1:0]       cur_fix;
   logic [N-1:0]       above_mask, below_mask;
   logic               move_go;
   logic [15:0]        eff_dwell;
   logic [31:0]        elapsed;

   assign rd_data = rd_valid_ff ? mem_rd_ff : psrt_pkg::reset_entry(rd_addr_ff);

   assign s_used     = used_ff[slot_ff];
   assign s_hot      = N'(1) << slot_ff;
   assign below_mask = s_hot - N'(1);
   assign above_mask = ~(below_mask | s_hot);
   assign fix_pick   = psrt_pkg::first_set(used_ff);
   assign cur_fix    = (!used_ff[cur_ff] && fix_pick.found) ? fix_pick.idx : cur_ff;
   assign next_pick  = psrt_pkg::next_after(used_ff, cur_ff, 1'b1);
   assign free_pick  = psrt_pkg::first_set(~used_ff);
   assign up_pick    = psrt_pkg::first_set(used_ff & above_mask);
   assign down_pick  = psrt_pkg::last_set(used_ff & below_mask);
   assign mv_pick    = flag_ff ? up_pick : down_pick;
   assign rm_pick    = psrt_pkg::first_set(used_ff & ~s_hot);
   assign move_go    = s_used && mv_pick.found && (slot_ff != W'(0)) && (mv_pick.idx != W'(0));
   assign eff_dwell  = (rd_data.dwell == 16'd0) ? psrt_pkg::DEFAULT_DWELL : rd_data.dwell;
   assign elapsed    = now_ff - last_ff;

   always_comb begin
      status.action = act_ff;
      case (act_ff)
         psrt_pkg::ACT_TICK:      status.go = en_ff && !psrt_pkg::in_quiet(qfrom_ff, qto_ff, hour_ff);
         psrt_pkg::ACT_SET_DWELL: status.go = s_used;
         psrt_pkg::ACT_MOVE:      status.go = move_go;
         default:                 status.go = 1'b0;
      endcase
   end

   always_comb begin
      used_in   = used_ff;
      active_in = active_ff;
      cur_in    = cur_ff;
      last_in   = last_ff;
      u_in      = u_ff;
      hold_in   = hold_ff;
      prod_in   = prod_ff;
      nxt_in    = nxt_ff;
      ok_in     = ok_ff;
      res_in    = res_ff;
      eu_in     = eu_ff;
      ea_in     = ea_ff;
      ek_in     = ek_ff;
      ed_in     = ed_ff;
      mem_we    = 1'b0;
      mem_wa    = slot_ff;
      mem_wd    = '0;
      rd_re     = 1'b0;
      rd_ra     = slot_ff;
      case (cmd.step)
         psrt_pkg::STEP_CAPTURE: begin
            ok_in  = 1'b0;
            res_in = '0;
            eu_in  = 1'b0;
            ea_in  = 1'b0;
            ek_in  = '0;
            ed_in  = '0;
         end
         psrt_pkg::STEP_EXEC: begin
            case (act_ff)
               psrt_pkg::ACT_TICK: begin
                  if (status.go) begin
                     cur_in = cur_fix;
                     rd_re  = 1'b1;
                     rd_ra  = cur_fix;
                     nxt_in = psrt_pkg::next_after(used_ff & active_ff, cur_fix, 1'b0);
                  end
               end
               psrt_pkg::ACT_DRAWN: begin
                  last_in = now_ff;
                  ok_in   = 1'b1;
               end
               psrt_pkg::ACT_GOTO: begin
                  if (s_used) begin
                     cur_in = slot_ff;
                     ok_in  = 1'b1;
                  end
               end
               psrt_pkg::ACT_NEXT: begin
                  if (next_pick.found) cur_in = next_pick.idx;
                  ok_in = 1'b1;
               end
               psrt_pkg::ACT_SET_ACTIVE: begin
                  if (s_used) begin
                     active_in[slot_ff] = flag_ff;
                     ok_in = 1'b1;
                  end
               end
               psrt_pkg::ACT_SET_DWELL: begin
                  rd_re = 1'b1;
               end
               psrt_pkg::ACT_PIN: begin
                  if (s_used) begin
                     active_in = s_hot;
                     cur_in    = slot_ff;
                     ok_in     = 1'b1;
                  end
               end
               psrt_pkg::ACT_ADD: begin
                  if (kind_ff < psrt_pkg::KIND_COUNT && free_pick.found) begin
                     used_in[free_pick.idx]   = 1'b1;
                     active_in[free_pick.idx] = 1'b0;
                     mem_we       = 1'b1;
                     mem_wa       = free_pick.idx;
                     mem_wd.kind  = kind_ff;
                     mem_wd.dwell = psrt_pkg::ADDED_DWELL;
                     ok_in        = 1'b1;
                     res_in       = free_pick.idx;
                  end
               end
               psrt_pkg::ACT_MOVE: begin
                  if (move_go) begin
                     u_in = mv_pick.idx;
                     used_in[slot_ff]        = used_ff[mv_pick.idx];
                     used_in[mv_pick.idx]    = used_ff[slot_ff];
                     active_in[slot_ff]      = active_ff[mv_pick.idx];
                     active_in[mv_pick.idx]  = active_ff[slot_ff];
                     if (cur_ff == slot_ff)          cur_in = mv_pick.idx;
                     else if (cur_ff == mv_pick.idx) cur_in = slot_ff;
                     rd_re = 1'b1;
                     ok_in = 1'b1;
                  end
               end
               psrt_pkg::ACT_REMOVE: begin
                  if (s_used && slot_ff != W'(0)) begin
                     used_in[slot_ff]   = 1'b0;
                     active_in[slot_ff] = 1'b0;
                     mem_we = 1'b1;
                     if (cur_ff == slot_ff && rm_pick.found) cur_in = rm_pick.idx;
                     ok_in = 1'b1;
                  end
               end
               psrt_pkg::ACT_READ: begin
                  rd_re = 1'b1;
                  ok_in = 1'b1;
                  eu_in = used_ff[slot_ff];
                  ea_in = active_ff[slot_ff];
               end
               default: ;
            endcase
         end
         psrt_pkg::STEP_TICK_MUL: begin
            prod_in = psrt_pkg::PROD_W'(eff_dwell) * psrt_pkg::PROD_W'(psrt_pkg::MS_PER_S);
         end
         psrt_pkg::STEP_TICK_CMP: begin
            if (elapsed >= 32'(prod_ff) && nxt_ff.found) begin
               ok_in  = 1'b1;
               res_in = nxt_ff.idx;
            end
         end
         psrt_pkg::STEP_MOVE_RD: begin
            hold_in = rd_data;
            rd_re   = 1'b1;
            rd_ra   = u_ff;
         end
         psrt_pkg::STEP_MOVE_WR_S: begin
            mem_we = 1'b1;
            mem_wd = rd_data;
         end
         psrt_pkg::STEP_MOVE_WR_U: begin
            mem_we = 1'b1;
            mem_wa = u_ff;
            mem_wd = hold_ff;
         end
         psrt_pkg::STEP_DWELL_WR: begin
            mem_we       = 1'b1;
            mem_wd.kind  = rd_data.kind;
            mem_wd.dwell = (dwell_ff < psrt_pkg::MIN_DWELL) ? psrt_pkg::MIN_DWELL : dwell_ff;
            ok_in        = 1'b1;
         end
         psrt_pkg::STEP_READ: begin
            ek_in = rd_data.kind;
            ed_in = rd_data.dwell;
         end
         default: ;
      endcase
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff       <= 1'b0;
         qfrom_ff    <= psrt_pkg::RESET_QFROM;
         qto_ff      <= psrt_pkg::RESET_QTO;
         used_ff     <= N'(3'b111);
         active_ff   <= N'(1);
         kd_valid_ff <= '0;
         cur_ff      <= '0;
         last_ff     <= '0;
      end else begin
         used_ff   <= used_in;
         active_ff <= active_in;
         cur_ff    <= cur_in;
         last_ff   <= last_in;
         if (mem_we) kd_valid_ff[mem_wa] <= 1'b1;
         if (csr_we) begin
            case (csr_index)
               psrt_pkg::CSR_ENABLE: en_ff <= csr_wdata[0];
               psrt_pkg::CSR_QFROM: begin
                  if (csr_wdata <= psrt_pkg::MAX_HOUR) qfrom_ff <= csr_wdata;
               end
               psrt_pkg::CSR_QTO: begin
                  if (csr_wdata <= psrt_pkg::MAX_HOUR) qto_ff <= csr_wdata;
               end
               default: ;
            endcase
         end
      end
   end

   // kind/dwell memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (rd_re) begin
         mem_rd_ff   <= mem[rd_ra];
         rd_valid_ff <= kd_valid_ff[rd_ra];
         rd_addr_ff  <= rd_ra;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.step == psrt_pkg::STEP_CAPTURE) begin
         act_ff   <= req_action;
         slot_ff  <= W'(req_slot);
         flag_ff  <= req_flag;
         dwell_ff <= req_dwell_seconds;
         kind_ff  <= req_page_kind;
         now_ff   <= req_now_ms;
         hour_ff  <= req_hour_of_day;
      end
      u_ff    <= u_in;
      hold_ff <= hold_in;
      prod_ff <= prod_in;
      nxt_ff  <= nxt_in;
      ok_ff   <= ok_in;
      res_ff  <= res_in;
      eu_ff   <= eu_in;
      ea_ff   <= ea_in;
      ek_ff   <= ek_in;
      ed_ff   <= ed_in;
      if (cmd.step == psrt_pkg::STEP_LOAD_RSP) begin
         rsp_ok           <= ok_ff;
         rsp_result_slot  <= 4'(res_ff);
         rsp_current_slot <= 4'(cur_ff);
         rsp_entry_used   <= eu_ff;
         rsp_entry_active <= ea_ff;
         rsp_entry_kind   <= ek_ff;
         rsp_entry_dwell  <= ed_ff;
      end
   end

endmodule

FILE: rtl/page_slot_rotation_table_top.sv
// Page slot rotation table top: one request in, one response out per request.
// Response valid follows execute, plus a read step for read, a write step for set dwell on a
// used slot, multiply and compare steps for a tick past the enable and quiet checks, and
// read and write steps for a slot swap. Take the next request once the response loads.
// Reset (synchronous, active high) restores slots 0..2, current slot 0, quiet 23..7.
// Depends on psrt_pkg, psrt_ctrl and psrt_dp.
module page_slot_rotation_table_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_action,
   input  logic [3:0]  req_slot,
   input  logic        req_flag,
   input  logic [15:0] req_dwell_seconds,
   input  logic [2:0]  req_page_kind,
   input  logic [31:0] req_now_ms,
   input  logic [4:0]  req_hour_of_day,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [3:0]  rsp_result_slot,
   output logic [3:0]  rsp_current_slot,
   output logic        rsp_entry_used,
   output logic        rsp_entry_active,
   output logic [2:0]  rsp_entry_kind,
   output logic [15:0] rsp_entry_dwell,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_wdata
);

   psrt_pkg::cmd_type    cmd;
   psrt_pkg::status_type status;

   // The user must change registers only while idle; unenforced, each write is taken at once.
   assign csr_ready = 1'b1;

   // Sequence each request: capture, execute, optional table steps, load response.
   // The kind/dwell table has registered reads and one write port, so a move swaps
   // its two entries one per cycle.
   psrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the table, timing state and the response payload.
   psrt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_action        (req_action),
      .req_slot          (req_slot),
      .req_flag          (req_flag),
      .req_dwell_seconds (req_dwell_seconds),
      .req_page_kind     (req_page_kind),
      .req_now_ms        (req_now_ms),
      .req_hour_of_day   (req_hour_of_day),
      .rsp_ok            (rsp_ok),
      .rsp_result_slot   (rsp_result_slot),
      .rsp_current_slot  (rsp_current_slot),
      .rsp_entry_used    (rsp_entry_used),
      .rsp_entry_active  (rsp_entry_active),
      .rsp_entry_kind    (rsp_entry_kind),
      .rsp_entry_dwell   (rsp_entry_dwell)
   );

endmodule

FILE: rtl/psrt_checker.sv
// Port-level checks for the page slot rotation table, bound to the top level.
// Depends on page_slot_rotation_table_top's port list only.
module psrt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_ok,
   input logic [3:0]  rsp_result_slot,
   input logic [3:0]  rsp_current_slot
);

   // one request at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while a request is in flight");

   // no new response appears in the cycle after an accept
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("response too early");

   // failed actions report slot zero
   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_result_slot == 4'd0)
      else $error("result slot set on failure");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_current_slot))
      else $error("stalled response changed");

endmodule

bind page_slot_rotation_table_top psrt_checker u_psrt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_ok           (rsp_ok),
   .rsp_result_slot  (rsp_result_slot),
   .rsp_current_slot (rsp_current_slot)
);

FILE: tb/tb.sv
// Self-checking testbench for page_slot_rotation_table_top: a directed plan, then random phases.
// Depends only on psrt_pkg (action and register codes, table constants) and the RTL top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 3;
   localparam int SETTLE       = 8;     // longest response path is a move
   localparam int STALL_LIMIT  = 4000;  // cycles with no handshake at all
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 180;

   localparam logic [3:0] ACT_FIRST_UNDEF = 4'd11;
   localparam logic [3:0] ACT_LAST_UNDEF  = 4'd15;
   localparam logic [1:0] CSR_SPARE       = 2'd3;

   // Idle mix per phase (phase index modulo 4): none, sender, receiver, both.
   localparam int REQ_IDLE [4] = '{0, 79, 0, 16};
   localparam int RSP_IDLE [4] = '{0, 0, 79, 16};

   // Register settings per phase; 31 is out of range and must leave the hour unchanged.
   localparam logic       PHASE_EN    [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1,
                                                   1'b1, 1'b1, 1'b1, 1'b1};
   localparam logic [4:0] PHASE_QFROM [PHASES] = '{5'd23, 5'd0, 5'd0, 5'd5,
                                                   5'd23, 5'd12, 5'd31, 5'd0};
   localparam logic [4:0] PHASE_QTO   [PHASES] = '{5'd7, 5'd0, 5'd23, 5'd20,
                                                   5'd0, 5'd12, 5'd31, 5'd23};

   typedef struct packed {
      logic [3:0]  action;
      logic [3:0]  slot;
      logic        flag;
      logic [15:0] dwell;
      logic [2:0]  kind;
      logic [31:0] now;
      logic [4:0]  hour;
   } request_type;

   typedef struct packed {
      logic        ok;
      logic [3:0]  pick;
      logic [3:0]  cur;
      logic        used;
      logic        active;
      logic [2:0]  kind;
      logic [15:0] dwell;
   } reply_type;

   typedef enum logic {ROW_REQ, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   reg_idx;
      logic [4:0]   reg_val;
      request_type  req;
      logic         typed;   // want holds a hand-written reply
      reply_type    want;
   } plan_row_type;

   // Directed plan: table extremes, every action, rejection paths, quiet-window
   // edges, wrapped elapsed time and ignored register writes.
   localparam int PLAN_ROWS = 32;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_READ, 4'd0, 1'b0, 16'd0, 3'd0, 32'd0, 5'd0}, typed: 1'b1,
        want: '{1'b1, 4'd0, 4'd0, 1'b1, 1'b1, 3'd0, 16'd600}, default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_READ, 4'd1, 1'b0, 16'd0, 3'd0, 32'd0, 5'd0}, typed: 1'b1,
        want: '{1'b1, 4'd0, 4'd0, 1'b1, 1'b0, 3'd1, 16'd300}, default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_READ, 4'd15, 1'b0, 16'd0, 3'd0, 32'd0, 5'd0}, typed: 1'b1,
        want: '{1'b1, 4'd0, 4'd0, 1'b0, 1'b0, 3'd0, 16'd0}, default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_TICK, 4'd0, 1'b0, 16'd0, 3'd0, 32'hFFFF_FFFF, 5'd12},
        typed: 1'b1, default: '0},
      '{kind: ROW_REQ, req: '{ACT_LAST_UNDEF, 4'd15, 1'b1, 16'hFFFF, 3'd7, 32'hFFFF_FFFF,
        5'd31}, typed: 1'b1, default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_GOTO, 4'd9, 1'b0, 16'd0, 3'd0, 32'd0, 5'd0}, typed: 1'b1,
        default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_ADD, 4'd0, 1'b0, 16'd0, 3'd7, 32'd0, 5'd0}, typed: 1'b1,
        default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_ADD, 4'd0, 1'b0, 16'd0, 3'd5, 32'd0, 5'd0}, typed: 1'b1,
        want: '{1'b1, 4'd3, 4'd0, 1'b0, 1'b0, 3'd0, 16'd0}, default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_MOVE, 4'd0, 1'b1, 16'd0, 3'd0, 32'd0, 5'd0}, typed: 1'b1,
        default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_MOVE, 4'd1, 1'b0, 16'd0, 3'd0, 32'd0, 5'd0}, typed: 1'b1,
        default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_REMOVE, 4'd0, 1'b0, 16'd0, 3'd0, 32'd0, 5'd0}, typed: 1'b1,
        default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_SET_DWELL, 4'd1, 1'b0, 16'd0, 3'd0, 32'd0, 5'd0},
        typed: 1'b1, want: '{1'b1, 4'd0, 4'd0, 1'b0, 1'b0, 3'd0, 16'd0}, default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_READ, 4'd1, 1'b0, 16'd0, 3'd0, 32'd0, 5'd0}, typed: 1'b1,
        want: '{1'b1, 4'd0, 4'd0, 1'b1, 1'b0, 3'd1, 16'd60}, default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_SET_DWELL, 4'd3, 1'b0, 16'hFFFF, 3'd0, 32'd0, 5'd0},
        default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_SET_ACTIVE, 4'd3, 1'b1, 16'd0, 3'd0, 32'd0, 5'd0},
        default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_MOVE, 4'd3, 1'b1, 16'd0, 3'd0, 32'd0, 5'd0}, default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_MOVE, 4'd3, 1'b0, 16'd0, 3'd0, 32'd0, 5'd0}, default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_NEXT, 4'd0, 1'b0, 16'd0, 3'd0, 32'd0, 5'd0}, default: '0},
      '{kind: ROW_REG, reg_idx: psrt_pkg::CSR_ENABLE, reg_val: 5'd1, default: '0},
      '{kind: ROW_REG, reg_idx: psrt_pkg::CSR_QFROM, reg_val: 5'd31, default: '0},
      '{kind: ROW_REG, reg_idx: psrt_pkg::CSR_QTO, reg_val: 5'd24, default: '0},
      '{kind: ROW_REG, reg_idx: CSR_SPARE, reg_val: 5'd31, default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_DRAWN, 4'd0, 1'b0, 16'd0, 3'd0, 32'hFFFF_F000, 5'd0},
        default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_TICK, 4'd0, 1'b0, 16'd0, 3'd0, 32'h0010_0000, 5'd2},
        default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_TICK, 4'd0, 1'b0, 16'd0, 3'd0, 32'h0010_0000, 5'd12},
        default: '0},
      '{kind: ROW_REG, reg_idx: psrt_pkg::CSR_QFROM, reg_val: 5'd0, default: '0},
      '{kind: ROW_REG, reg_idx: psrt_pkg::CSR_QTO, reg_val: 5'd23, default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_TICK, 4'd0, 1'b0, 16'd0, 3'd0, 32'h0010_0000, 5'd31},
        default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_TICK, 4'd0, 1'b0, 16'd0, 3'd0, 32'h0010_0000, 5'd0},
        default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_PIN, 4'd2, 1'b0, 16'd0, 3'd0, 32'd0, 5'd0}, default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_TICK, 4'd0, 1'b0, 16'd0, 3'd0, 32'h0010_0000, 5'd23},
        default: '0},
      '{kind: ROW_REQ,
        req: '{psrt_pkg::ACT_REMOVE, 4'd2, 1'b0, 16'd0, 3'd0, 32'd0, 5'd0}, default: '0}
   };

   // ---------------------------------------------------------------- DUT ports
   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [3:0]  req_action;
   logic [3:0]  req_slot;
   logic        req_flag;
   logic [15:0] req_dwell_seconds;
   logic [2:0]  req_page_kind;
   logic [31:0] req_now_ms;
   logic [4:0]  req_hour_of_day;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_ok;
   logic [3:0]  rsp_result_slot;
   logic [3:0]  rsp_current_slot;
   logic        rsp_entry_used;
   logic        rsp_entry_active;
   logic [2:0]  rsp_entry_kind;
   logic [15:0] rsp_entry_dwell;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [4:0]  csr_wdata;

   page_slot_rotation_table_top i_dut (.*);

   // ------------------------------------------------- shadow copy of the table
   logic        tbl_used   [psrt_pkg::SLOT_COUNT];
   logic        tbl_active [psrt_pkg::SLOT_COUNT];
   logic [2:0]  tbl_kind   [psrt_pkg::SLOT_COUNT];
   logic [15:0] tbl_dwell  [psrt_pkg::SLOT_COUNT];
   logic [3:0]  on_screen;
   logic [31:0] last_draw;
   logic        cfg_rotate;
   logic [4:0]  cfg_qfrom;
   logic [4:0]  cfg_qto;

   reply_type replies_due [$];
   reply_type due;

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int n_errors      = 0;
   int n_requests    = 0;
   int n_replies     = 0;
   int n_proposals   = 0;
   int n_reg_writes  = 0;

   always #HALF_PERIOD clock = ~clock;

   function automatic logic [3:0] lowest_used();
      logic [3:0] idx;
      idx = '0;
      for (int k = psrt_pkg::SLOT_COUNT - 1; k >= 0; k--) begin
         if (tbl_used[k]) idx = 4'(k);
      end
      return idx;
   endfunction

   // Apply one request to the shadow table and return the reply it must produce.
   function automatic reply_type step_slot_table(input request_type r);
      reply_type   y;
      logic        quiet;
      logic        hit;
      logic [3:0]  base;
      logic [3:0]  u;
      logic [15:0] d;
      int          j;
      int          dir;
      logic        t_used;
      logic        t_active;
      logic [2:0]  t_kind;
      logic [15:0] t_dwell;
      y = '0;
      case (r.action)
         psrt_pkg::ACT_TICK: begin
            if (cfg_qfrom == cfg_qto)    quiet = 1'b0;
            else if (cfg_qfrom < cfg_qto) quiet = r.hour >= cfg_qfrom && r.hour < cfg_qto;
            else                          quiet = r.hour >= cfg_qfrom || r.hour < cfg_qto;
            if (cfg_rotate && !quiet) begin
               // fall back to the lowest used slot first; this sticks even without a pick
               if (!tbl_used[on_screen]) on_screen = lowest_used();
               d = tbl_dwell[on_screen];
               if (d == '0) d = psrt_pkg::DEFAULT_DWELL;
               if (r.now - last_draw >= 32'(d) * 32'(psrt_pkg::MS_PER_S)) begin
                  for (int k = 1; k < psrt_pkg::SLOT_COUNT; k++) begin
                     u = on_screen + 4'(k);
                     if (!y.ok && tbl_used[u] && tbl_active[u]) begin
                        y.ok   = 1'b1;
                        y.pick = u;
                     end
                  end
               end
            end
         end
         psrt_pkg::ACT_DRAWN: begin
            last_draw = r.now;
            y.ok      = 1'b1;
         end
         psrt_pkg::ACT_GOTO: begin
            if (tbl_used[r.slot]) begin
               on_screen = r.slot;
               y.ok      = 1'b1;
            end
         end
         psrt_pkg::ACT_NEXT: begin
            base = on_screen;
            hit  = 1'b0;
            for (int k = 1; k <= psrt_pkg::SLOT_COUNT; k++) begin
               u = base + 4'(k);
               if (!hit && tbl_used[u]) begin
                  hit       = 1'b1;
                  on_screen = u;
               end
            end
            y.ok = 1'b1;
         end
         psrt_pkg::ACT_SET_ACTIVE: begin
            if (tbl_used[r.slot]) begin
               tbl_active[r.slot] = r.flag;
               y.ok               = 1'b1;
            end
         end
         psrt_pkg::ACT_SET_DWELL: begin
            if (tbl_used[r.slot]) begin
               tbl_dwell[r.slot] = (r.dwell < psrt_pkg::MIN_DWELL) ? psrt_pkg::MIN_DWELL
                                                                    : r.dwell;
               y.ok              = 1'b1;
            end
         end
         psrt_pkg::ACT_PIN: begin
            if (tbl_used[r.slot]) begin
               for (int k = 0; k < psrt_pkg::SLOT_COUNT; k++)
                  tbl_active[k] = (4'(k) == r.slot);
               on_screen = r.slot;
               y.ok      = 1'b1;
            end
         end
         psrt_pkg::ACT_ADD: begin
            if (r.kind < psrt_pkg::KIND_COUNT) begin
               for (int k = 0; k < psrt_pkg::SLOT_COUNT; k++) begin
                  if (!y.ok && !tbl_used[k]) begin
                     tbl_used[k]   = 1'b1;
                     tbl_active[k] = 1'b0;
                     tbl_kind[k]   = r.kind;
                     tbl_dwell[k]  = psrt_pkg::ADDED_DWELL;
                     y.ok          = 1'b1;
                     y.pick        = 4'(k);
                  end
               end
            end
         end
         psrt_pkg::ACT_MOVE: begin
            if (tbl_used[r.slot]) begin
               dir = r.flag ? 1 : -1;
               j   = int'(r.slot) + dir;
               while (j >= 0 && j < psrt_pkg::SLOT_COUNT && !tbl_used[j]) j += dir;
               if (j >= 0 && j < psrt_pkg::SLOT_COUNT && r.slot != '0 && j != 0) begin
                  u        = 4'(j);
                  t_used   = tbl_used[r.slot];
                  t_active = tbl_active[r.slot];
                  t_kind   = tbl_kind[r.slot];
                  t_dwell  = tbl_dwell[r.slot];
                  tbl_used[r.slot]   = tbl_used[u];
                  tbl_active[r.slot] = tbl_active[u];
                  tbl_kind[r.slot]   = tbl_kind[u];
                  tbl_dwell[r.slot]  = tbl_dwell[u];
                  tbl_used[u]   = t_used;
                  tbl_active[u] = t_active;
                  tbl_kind[u]   = t_kind;
                  tbl_dwell[u]  = t_dwell;
                  // the page on screen follows its entry
                  if (on_screen == r.slot) on_screen = u;
                  else if (on_screen == u) on_screen = r.slot;
                  y.ok = 1'b1;
               end
            end
         end
         psrt_pkg::ACT_REMOVE: begin
            if (tbl_used[r.slot] && r.slot != '0) begin
               tbl_used[r.slot]   = 1'b0;
               tbl_active[r.slot] = 1'b0;
               tbl_kind[r.slot]   = '0;
               tbl_dwell[r.slot]  = '0;
               if (on_screen == r.slot) on_screen = lowest_used();
               y.ok = 1'b1;
            end
         end
         psrt_pkg::ACT_READ: begin
            y.ok     = 1'b1;
            y.used   = tbl_used[r.slot];
            y.active = tbl_active[r.slot];
            y.kind   = tbl_kind[r.slot];
            y.dwell  = tbl_dwell[r.slot];
         end
         default: ;
      endcase
      y.cur = on_screen;
      return y;
   endfunction

   // Mostly well-formed requests: used slots, legal kinds and hours, tick times near
   // the dwell boundary; the rest is full-range noise.
   function automatic request_type random_request();
      request_type q;
      int          roll;
      logic [3:0]  shown;
      logic [15:0] d;
      roll = $urandom_range(99);
      if (roll < 22)      q.action = psrt_pkg::ACT_TICK;
      else if (roll < 30) q.action = psrt_pkg::ACT_DRAWN;
      else if (roll < 37) q.action = psrt_pkg::ACT_GOTO;
      else if (roll < 43) q.action = psrt_pkg::ACT_NEXT;
      else if (roll < 53) q.action = psrt_pkg::ACT_SET_ACTIVE;
      else if (roll < 59) q.action = psrt_pkg::ACT_SET_DWELL;
      else if (roll < 63) q.action = psrt_pkg::ACT_PIN;
      else if (roll < 73) q.action = psrt_pkg::ACT_ADD;
      else if (roll < 83) q.action = psrt_pkg::ACT_MOVE;
      else if (roll < 91) q.action = psrt_pkg::ACT_REMOVE;
      else if (roll < 98) q.action = psrt_pkg::ACT_READ;
      else                q.action = 4'($urandom_range(ACT_LAST_UNDEF, ACT_FIRST_UNDEF));
      q.slot = 4'($urandom_range(psrt_pkg::SLOT_COUNT - 1));
      if ($urandom_range(99) < 80) begin
         // slot 0 is always used, so this settles
         while (!tbl_used[q.slot]) q.slot = 4'($urandom_range(psrt_pkg::SLOT_COUNT - 1));
      end
      if (q.action == psrt_pkg::ACT_SET_ACTIVE) q.flag = ($urandom_range(99) < 70);
      else                                      q.flag = 1'($urandom_range(1));
      q.dwell = $urandom_range(1) ? 16'($urandom_range(120)) : 16'($urandom_range(16'hFFFF));
      q.kind  = ($urandom_range(99) < 85) ? 3'($urandom_range(5)) : 3'($urandom_range(7, 6));
      q.hour  = ($urandom_range(99) < 85) ? 5'($urandom_range(23)) : 5'($urandom_range(31, 24));
      q.now   = $urandom();
      if (q.action == psrt_pkg::ACT_TICK && $urandom_range(99) < 60) begin
         shown = tbl_used[on_screen] ? on_screen : lowest_used();
         d     = tbl_dwell[shown];
         if (d == '0) d = psrt_pkg::DEFAULT_DWELL;
         q.now = last_draw + 32'(d) * 32'(psrt_pkg::MS_PER_S) + 32'($urandom_range(3000))
                 - 32'd1500;
      end else if (q.action == psrt_pkg::ACT_DRAWN && $urandom_range(1)) begin
         q.now = last_draw + 32'($urandom_range(200000));
      end
      return q;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      n_errors++;
   endtask

   // Present one request at the falling edge, hold it while stalled, and log the
   // reply it must produce once it is taken.
   task automatic send_request(input request_type q, input logic typed,
                               input reply_type want);
      reply_type y;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_action        = q.action;
      req_slot          = q.slot;
      req_flag          = q.flag;
      req_dwell_seconds = q.dwell;
      req_page_kind     = q.kind;
      req_now_ms        = q.now;
      req_hour_of_day   = q.hour;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      y = step_slot_table(q);
      if (q.action == psrt_pkg::ACT_TICK && y.ok) n_proposals++;
      replies_due.push_back(typed ? want : y);
      n_requests++;
      @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [4:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      // hour registers drop values above 23; the spare index has no register behind it
      case (idx)
         psrt_pkg::CSR_ENABLE: cfg_rotate = val[0];
         psrt_pkg::CSR_QFROM:  if (val <= psrt_pkg::MAX_HOUR) cfg_qfrom = val;
         psrt_pkg::CSR_QTO:    if (val <= psrt_pkg::MAX_HOUR) cfg_qto = val;
         default: ;
      endcase
      n_reg_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Drop the request valid, drain every outstanding reply, then let the block settle.
   task automatic quiesce();
      req_valid = 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // Receiver: stall at random, decided at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Reply checker: compare every taken reply with the oldest one due.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         n_replies++;
         if (replies_due.size() == 0) begin
            report_mismatch("reply with none due, current_slot", 32'(rsp_current_slot),
                            32'd0);
         end else begin
            due = replies_due.pop_front();
            if (rsp_ok !== due.ok)
               report_mismatch("ok", 32'(rsp_ok), 32'(due.ok));
            if (rsp_result_slot !== due.pick)
               report_mismatch("result_slot", 32'(rsp_result_slot), 32'(due.pick));
            if (rsp_current_slot !== due.cur)
               report_mismatch("current_slot", 32'(rsp_current_slot), 32'(due.cur));
            if (rsp_entry_used !== due.used)
               report_mismatch("entry_used", 32'(rsp_entry_used), 32'(due.used));
            if (rsp_entry_active !== due.active)
               report_mismatch("entry_active", 32'(rsp_entry_active), 32'(due.active));
            if (rsp_entry_kind !== due.kind)
               report_mismatch("entry_kind", 32'(rsp_entry_kind), 32'(due.kind));
            if (rsp_entry_dwell !== due.dwell)
               report_mismatch("entry_dwell", 32'(rsp_entry_dwell), 32'(due.dwell));
         end
      end
   end

   // Watchdog: end the run if no channel moves anything for too long.
   initial begin : watchdog
      int dead_cycles;
      dead_cycles = 0;
      while (dead_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            dead_cycles = 0;
         else
            dead_cycles++;
      end
      $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, STALL_LIMIT);
      $display("page_slot_rotation_table_top verification failed");
      $finish;
   end

   initial begin : stimulus
      plan_row_type row;
      int           ph;
      // Drive every input to a known value before the first edge.
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = psrt_pkg::ACT_TICK;
      req_slot          = '0;
      req_flag          = 1'b0;
      req_dwell_seconds = '0;
      req_page_kind     = '0;
      req_now_ms        = '0;
      req_hour_of_day   = '0;
      csr_valid         = 1'b0;
      csr_index         = psrt_pkg::CSR_ENABLE;
      csr_wdata         = '0;

      // Shadow table at reset: slots 0..2 used, only slot 0 active.
      for (int k = 0; k < psrt_pkg::SLOT_COUNT; k++) begin
         tbl_used[k]   = (k < 3);
         tbl_active[k] = (k == 0);
         tbl_kind[k]   = (k < 3) ? 3'(k) : 3'd0;
         tbl_dwell[k]  = (k == 0) ? psrt_pkg::DEFAULT_DWELL
                                  : ((k < 3) ? psrt_pkg::ADDED_DWELL : 16'd0);
      end
      on_screen  = '0;
      last_draw  = '0;
      cfg_rotate = 1'b0;
      cfg_qfrom  = psrt_pkg::RESET_QFROM;
      cfg_qto    = psrt_pkg::RESET_QTO;

      // Hold reset, then release it away from the clock edge.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed plan: register rows only go in once the block has drained.
      for (int i = 0; i < PLAN_ROWS; i++) begin
         row = PLAN[i];
         if (row.kind == ROW_REG) begin
            quiesce();
            write_register(row.reg_idx, row.reg_val);
         end else begin
            send_request(row.req, row.typed, row.want);
         end
      end

      // Random phases: each one sets the registers, then runs under one idle mix.
      for (ph = 0; ph < PHASES; ph++) begin
         quiesce();
         req_idle_pct  = REQ_IDLE[ph % 4];
         rsp_stall_pct = RSP_IDLE[ph % 4];
         write_register(psrt_pkg::CSR_ENABLE, {4'd0, PHASE_EN[ph]});
         write_register(psrt_pkg::CSR_QFROM, PHASE_QFROM[ph]);
         write_register(psrt_pkg::CSR_QTO, PHASE_QTO[ph]);
         for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request(), 1'b0, '0);
      end

      // Drain and give any stray reply time to show up.
      quiesce();
      rsp_stall_pct = 0;
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d requests with %0d tick proposals, %0d replies, %0d register writes",
               n_requests, n_proposals, n_replies, n_reg_writes);
      $display("idle mixes none/sender/receiver/both over %0d register settings", PHASES);
      if (n_errors == 0) begin
         $display("page_slot_rotation_table_top verification clean");
      end else begin
         $display("page_slot_rotation_table_top verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/psrt_pkg.sv
rtl/psrt_ctrl.sv
rtl/psrt_dp.sv
rtl/page_slot_rotation_table_top.sv
rtl/psrt_checker.sv
tb/tb.sv
